// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros shared by the checker files
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low
`define AST_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is low
`define AST_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/gsppm_pkg.sv =====
// ----------------------------------------------------------------------------
// gsppm_pkg
// Codes, constants and elaboration helpers of the gas sensor linearizer.
// ----------------------------------------------------------------------------
package gsppm_pkg;

  typedef logic [1:0] status_t;

  localparam status_t ST_OK   = 2'd0;
  localparam status_t ST_ZERO = 2'd1;
  localparam status_t ST_SAT  = 2'd2;

  localparam logic KIND_MEASURE = 1'b0;
  localparam logic KIND_CAL     = 1'b1;

  // Curve constants in Q24
  localparam longint LOG2_K_Q24   = 64'd111055808;
  localparam logic [31:0] EXPO_Q24     = 32'd24461181;
  localparam logic [31:0] INV_EXPO_Q24 = 32'd11507007;

  localparam logic [23:0] PPM_MAX = 24'hFFFFFF;
  localparam logic [31:0] R0_MAX  = 32'hFFFFFFFF;

  // Register indexes
  localparam logic [2:0] REG_LOAD_RES  = 3'd0;
  localparam logic [2:0] REG_CAL_PPM   = 3'd1;
  localparam logic [2:0] REG_CAL_GAIN  = 3'd2;
  localparam logic [2:0] REG_OUT_GAIN  = 3'd3;
  localparam logic [2:0] REG_INIT_R0   = 3'd4;

  // Integer square root, bit-pair method (elaboration only)
  function automatic logic [63:0] isqrt64(input logic [63:0] v_in);
    logic [63:0] v;
    logic [63:0] r;
    logic [63:0] b;
    v = v_in;
    r = 64'd0;
    b = 64'd1 << 62;
    for (int k = 0; k < 32; k++) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Q30 root 2^(2^-(i+1)), each one the square root of the previous
  function automatic logic [31:0] exp_root(input int i);
    logic [63:0] r;
    r = 64'd2 << 30;
    for (int k = 0; k <= i; k++) begin
      r = isqrt64(r << 30);
    end
    return r[31:0];
  endfunction

endpackage

// ===== hdl/gas_sensor_ppm_linearizer.sv =====
// ----------------------------------------------------------------------------
// gas_sensor_ppm_linearizer
// Power-law ppm linearizer for a metal-oxide gas sensor divider, built as one
// shared multiplier under a small sequencer (log2 by squaring, exp2 by roots).
// ----------------------------------------------------------------------------
//  channel | direction | transaction
//  in_     | slave     | tuser: kind, tdata: adc_sample
//  out_    | master    | tuser: status, tdata: ppm_value, ref_resistance
//  cfg_    | APB       | register write / read, always ready
//
//  An item runs through S_NUM, then four log jobs of S_NORM, S_SQ and S_ACC,
//  then S_MULQ, S_EXP and S_FIN; the single multiplier does every square and
//  product. Zero samples and other fixed results go from intake to S_FIN.
//  Reset is synchronous; registers return to their documented values.
//  A result waits in the output register; in_tready drops while busy and the
//  next result waits for the previous one to be taken.
// ----------------------------------------------------------------------------
module gas_sensor_ppm_linearizer #(
  parameter int ADC_BITS  = 12,
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [((ADC_BITS+7)/8)*8-1:0]       in_tdata,   // adc_sample
  input  logic [0:0]                          in_tuser,   // kind
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [55:0]                         out_tdata,  // ppm_value, ref_resistance
  output logic [1:0]                          out_tuser,  // status
  input  logic                                cfg_psel,
  input  logic                                cfg_penable,
  input  logic                                cfg_pwrite,
  input  logic [4:0]                          cfg_paddr,
  input  logic [31:0]                         cfg_pwdata,
  output logic [31:0]                         cfg_prdata,
  output logic                                cfg_pready
);

  localparam int NW  = (20 + ADC_BITS > 32) ? 20 + ADC_BITS : 32;
  localparam int SW  = $clog2(NW);
  localparam int EW  = FRAC_BITS + 9;
  localparam int IPW = EW - FRAC_BITS;
  localparam int CW  = $clog2(FRAC_BITS);
  localparam int QSH = 24 - FRAC_BITS;
  localparam longint K_HALF = (64'd1 << QSH) >> 1;
  localparam logic signed [EW-1:0] K_Q = EW'((gsppm_pkg::LOG2_K_Q24 + K_HALF) >>> QSH);
  localparam logic signed [EW-1:0] ONE = EW'(64'd1 << FRAC_BITS);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_NUM  = 3'd1;
  localparam logic [2:0] S_NORM = 3'd2;
  localparam logic [2:0] S_SQ   = 3'd3;
  localparam logic [2:0] S_ACC  = 3'd4;
  localparam logic [2:0] S_MULQ = 3'd5;
  localparam logic [2:0] S_EXP  = 3'd6;
  localparam logic [2:0] S_FIN  = 3'd7;

  // exp2 root table
  logic [31:0] roots [FRAC_BITS];
  for (genvar g = 0; g < FRAC_BITS; g++) begin : g_root
    localparam logic [31:0] ROOT = gsppm_pkg::exp_root(g);
    assign roots[g] = ROOT;
  end

  // Configuration registers
  logic [19:0] load_res_r;
  logic [15:0] cal_ppm_r, cal_gain_r, out_gain_r;
  logic [31:0] init_r0_r;
  logic        cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_res_r <= 20'd10000;
      cal_ppm_r  <= 16'd10;
      cal_gain_r <= 16'd320;
      out_gain_r <= 16'd256;
      init_r0_r  <= 32'd10000;
    end else if (cfg_wr) begin
      case (cfg_paddr[4:2])
        gsppm_pkg::REG_LOAD_RES: load_res_r <= cfg_pwdata[19:0];
        gsppm_pkg::REG_CAL_PPM:  cal_ppm_r  <= cfg_pwdata[15:0];
        gsppm_pkg::REG_CAL_GAIN: cal_gain_r <= cfg_pwdata[15:0];
        gsppm_pkg::REG_OUT_GAIN: out_gain_r <= cfg_pwdata[15:0];
        gsppm_pkg::REG_INIT_R0:  init_r0_r  <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (cfg_paddr[4:2])
      gsppm_pkg::REG_LOAD_RES: cfg_prdata = {12'd0, load_res_r};
      gsppm_pkg::REG_CAL_PPM:  cfg_prdata = {16'd0, cal_ppm_r};
      gsppm_pkg::REG_CAL_GAIN: cfg_prdata = {16'd0, cal_gain_r};
      gsppm_pkg::REG_OUT_GAIN: cfg_prdata = {16'd0, out_gain_r};
      gsppm_pkg::REG_INIT_R0:  cfg_prdata = init_r0_r;
      default:                 cfg_prdata = 32'd0;
    endcase
  end

  // Datapath and control registers
  logic [2:0]           state_r;
  logic                 kind_r, skip_r, wr_r0_r;
  logic [ADC_BITS-1:0]  adc_r;
  logic [31:0]          r0u_r;
  logic [23:0]          pre_ppm_r;
  gsppm_pkg::status_t   pre_st_r;
  logic [NW-1:0]        xr_r;
  logic [SW-1:0]        sh_r;
  logic [31:0]          m_r;
  logic [FRAC_BITS-1:0] frac_r;
  logic [CW-1:0]        cnt_r;
  logic [1:0]           job_r;
  logic signed [EW-1:0] e_r, l_r;
  logic [31:0]          ref_r0_r;
  logic                 calib_r;
  logic                 out_valid_r;
  logic [23:0]          out_ppm_r;
  logic [31:0]          out_ref_r;
  gsppm_pkg::status_t   out_st_r;

  logic [ADC_BITS-1:0] adc_in, full;
  assign adc_in    = in_tdata[ADC_BITS-1:0];
  assign full      = {ADC_BITS{1'b1}};
  assign in_tready = (state_r == S_IDLE);

  // Shared multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic [EW-1:0] l_mag;
  assign l_mag = l_r[EW-1] ? EW'(-l_r) : EW'(l_r);

  always_comb begin
    case (state_r)
      S_NUM:   begin mul_a = {12'd0, load_res_r};
                     mul_b = 32'(full - adc_r); end
      S_SQ:    begin mul_a = m_r; mul_b = m_r; end
      S_MULQ:  begin mul_a = 32'(l_mag);
                     mul_b = kind_r ? gsppm_pkg::INV_EXPO_Q24 : gsppm_pkg::EXPO_Q24; end
      S_EXP:   begin mul_a = m_r; mul_b = roots[cnt_r]; end
      default: begin mul_a = 32'd0; mul_b = 32'd0; end
    endcase
  end
  assign prod = 64'(mul_a) * 64'(mul_b);

  // Log step helpers
  logic [31:0] sq_t;
  logic [SW-1:0] n_log;
  logic signed [EW-1:0] log_val;
  assign sq_t    = prod[61:30];
  assign n_log   = SW'(NW - 1) - sh_r;
  assign log_val = (EW'(n_log) << FRAC_BITS) | EW'(frac_r);

  // Rounded Q24 scaling of the log term
  logic [63:0] q_rnd;
  logic signed [EW-1:0] q_val;
  assign q_rnd = (prod + (64'd1 << 23)) >> 24;
  assign q_val = (l_r[EW-1] ^ ~kind_r) ? -EW'(q_rnd) : EW'(q_rnd);

  // Rounded root product
  logic [63:0] ex_rnd;
  assign ex_rnd = prod + (64'd1 << 29);

  // Operand for the next log job
  logic [NW-1:0] job_x;
  always_comb begin
    case (job_r)
      2'd0:    job_x = NW'(adc_r);
      2'd1:    job_x = (kind_r == gsppm_pkg::KIND_MEASURE) ? NW'(r0u_r) : NW'(cal_gain_r);
      default: job_x = (kind_r == gsppm_pkg::KIND_MEASURE) ? NW'(out_gain_r) : NW'(cal_ppm_r);
    endcase
  end

  // Target and sign of a log job: measure L+,L-,L-,E+; calibrate E+,E-,E+,L+
  logic to_l, neg_job;
  always_comb begin
    if (kind_r == gsppm_pkg::KIND_MEASURE) begin
      to_l    = (job_r != 2'd3);
      neg_job = (job_r == 2'd1) || (job_r == 2'd2);
    end else begin
      to_l    = (job_r == 2'd3);
      neg_job = (job_r == 2'd1);
    end
  end

  // Final shift of the exp2 mantissa
  logic signed [IPW-1:0] ip;
  logic signed [IPW:0]   s_val;
  logic [40:0]           v_fin;
  logic [33:0]           v_sum;
  assign ip    = e_r[EW-1:FRAC_BITS];
  assign s_val = (IPW+1)'(30) - {ip[IPW-1], ip};
  always_comb begin
    v_sum = 34'(m_r) + (34'd1 << (s_val[5:0] - 6'd1));
    if (ip >= 34) begin
      v_fin = 41'd1 << 40;
    end else if (ip >= 30) begin
      v_fin = 41'(m_r) << (2'(ip - 30));
    end else if (s_val > 32) begin
      v_fin = 41'd0;
    end else begin
      v_fin = 41'(v_sum >> s_val[5:0]);
    end
  end

  // Result assembly
  logic [23:0]        fin_ppm;
  logic [31:0]        fin_r0, fin_ref;
  gsppm_pkg::status_t fin_st;
  logic               fin_go;
  always_comb begin
    fin_r0 = (v_fin > 41'(gsppm_pkg::R0_MAX)) ? gsppm_pkg::R0_MAX : v_fin[31:0];
    if (skip_r) begin
      fin_ppm = pre_ppm_r;
      fin_st  = pre_st_r;
      fin_r0  = 32'd0;
    end else if (kind_r == gsppm_pkg::KIND_MEASURE) begin
      if (v_fin > 41'(gsppm_pkg::PPM_MAX)) begin
        fin_ppm = gsppm_pkg::PPM_MAX;
        fin_st  = gsppm_pkg::ST_SAT;
      end else begin
        fin_ppm = v_fin[23:0];
        fin_st  = gsppm_pkg::ST_OK;
      end
    end else begin
      fin_ppm = 24'd0;
      fin_st  = gsppm_pkg::ST_OK;
    end
    fin_ref = wr_r0_r ? fin_r0 : r0u_r;
  end
  assign fin_go = (state_r == S_FIN) && (!out_valid_r || out_tready);

  // Intake decode of fixed results
  logic zero_in, numz_in;
  logic [31:0] r0u_in;
  assign zero_in = (adc_in == '0);
  assign numz_in = (adc_in == full) || (load_res_r == 20'd0);
  assign r0u_in  = calib_r ? ref_r0_r : init_r0_r;

  // Control sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ref_r0_r <= 32'd0;
      calib_r  <= 1'b0;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            kind_r    <= in_tuser[0];
            adc_r     <= adc_in;
            r0u_r     <= r0u_in;
            job_r     <= 2'd0;
            pre_ppm_r <= 24'd0;
            pre_st_r  <= gsppm_pkg::ST_OK;
            wr_r0_r   <= (in_tuser[0] == gsppm_pkg::KIND_CAL) && !zero_in;
            skip_r    <= 1'b1;
            state_r   <= S_FIN;
            if (in_tuser[0] == gsppm_pkg::KIND_MEASURE) begin
              e_r <= K_Q - (ONE <<< 2);
              l_r <= '0;
            end else begin
              e_r <= -(ONE <<< 3);
              l_r <= -K_Q;
            end
            if (zero_in) begin
              pre_st_r <= gsppm_pkg::ST_ZERO;
            end else if (in_tuser[0] == gsppm_pkg::KIND_MEASURE) begin
              if (r0u_in == 32'd0 || out_gain_r == 16'd0) begin
                pre_st_r <= gsppm_pkg::ST_OK;
              end else if (numz_in) begin
                pre_ppm_r <= gsppm_pkg::PPM_MAX;
                pre_st_r  <= gsppm_pkg::ST_SAT;
              end else begin
                skip_r  <= 1'b0;
                state_r <= S_NUM;
              end
            end else if (!(numz_in || cal_gain_r == 16'd0 || cal_ppm_r == 16'd0)) begin
              skip_r  <= 1'b0;
              state_r <= S_NUM;
            end
          end
        end
        S_NUM: begin
          xr_r    <= prod[NW-1:0];
          sh_r    <= '0;
          state_r <= S_NORM;
        end
        // Normalize: by a byte while the top byte is clear, else by a bit
        S_NORM: begin
          if (xr_r[NW-1]) begin
            m_r     <= {1'b0, xr_r[NW-1 -: 31]};
            frac_r  <= '0;
            cnt_r   <= '0;
            state_r <= S_SQ;
          end else if (xr_r[NW-1 -: 8] == 8'd0) begin
            xr_r <= xr_r << 8;
            sh_r <= sh_r + SW'(8);
          end else begin
            xr_r <= xr_r << 1;
            sh_r <= sh_r + SW'(1);
          end
        end
        // One fraction bit per squaring
        S_SQ: begin
          if (sq_t[31]) begin
            m_r    <= sq_t >> 1;
            frac_r <= {frac_r[FRAC_BITS-2:0], 1'b1};
          end else begin
            m_r    <= sq_t;
            frac_r <= {frac_r[FRAC_BITS-2:0], 1'b0};
          end
          cnt_r <= cnt_r + CW'(1);
          if (cnt_r == CW'(FRAC_BITS - 1)) state_r <= S_ACC;
        end
        S_ACC: begin
          if (to_l) l_r <= neg_job ? l_r - log_val : l_r + log_val;
          else      e_r <= neg_job ? e_r - log_val : e_r + log_val;
          if (job_r == 2'd3) begin
            state_r <= S_MULQ;
          end else begin
            job_r   <= job_r + 2'd1;
            xr_r    <= job_x;
            sh_r    <= '0;
            state_r <= S_NORM;
          end
        end
        S_MULQ: begin
          e_r     <= e_r + q_val;
          m_r     <= 32'd1 << 30;
          cnt_r   <= '0;
          state_r <= S_EXP;
        end
        // Product of roots selected by the fraction bits, high bit first
        S_EXP: begin
          if (e_r[CW'(FRAC_BITS - 1) - cnt_r]) m_r <= ex_rnd[61:30];
          cnt_r <= cnt_r + CW'(1);
          if (cnt_r == CW'(FRAC_BITS - 1)) state_r <= S_FIN;
        end
        S_FIN: begin
          if (fin_go) begin
            if (wr_r0_r) begin
              ref_r0_r <= fin_r0;
              calib_r  <= 1'b1;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_go) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_go) begin
      out_ppm_r <= fin_ppm;
      out_ref_r <= fin_ref;
      out_st_r  <= fin_st;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_ref_r, out_ppm_r};
  assign out_tuser  = out_st_r;

endmodule

// ===== hdl/gsppm_checker.sv =====
// ----------------------------------------------------------------------------
// gsppm_checker
// Port-level checks of the linearizer, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gsppm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [55:0] out_tdata,
  input logic [1:0]  out_tuser
);

  // A stalled result stays offered
  `AST_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid, "result dropped")

  // The block is busy right after it takes an item
  `AST_NXT(a_busy, clk, rst_n, in_tvalid && in_tready, !in_tready, "ready after accept")

  // No undefined status code
  `AST_IMP(a_status, clk, rst_n, out_tvalid, out_tuser != 2'd3, "bad status")

  // A rejected sample carries no concentration
  `AST_IMP(a_zero, clk, rst_n, out_tvalid && out_tuser == gsppm_pkg::ST_ZERO,
    out_tdata[23:0] == 24'd0, "ppm on zero sample")

endmodule

bind gas_sensor_ppm_linearizer gsppm_checker u_gsppm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

// ===== tb/sv/gas_sensor_ppm_linearizer_tb.sv =====
// ----------------------------------------------------------------------------
// gas_sensor_ppm_linearizer_tb
// Self-checking bench: drives measure and calibrate transactions, predicts each
// result in fixed point (log2 by squaring, exp2 by roots) and compares fields.
// ----------------------------------------------------------------------------
module gas_sensor_ppm_linearizer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FB = 16;
  localparam longint ONE = 64'sd1 << FB;
  localparam longint FULL_SCALE = 4095;

  typedef struct packed {
    logic [23:0] ppm;
    logic [31:0] r0;
    logic [1:0]  st;
  } reading_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [15:0] in_tdata = '0;      // adc_sample [11:0], zero fill
  logic [0:0] in_tuser = '0;       // kind
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [55:0] out_tdata;          // ppm_value [23:0], ref_resistance [55:24]
  logic [1:0] out_tuser;           // status
  logic cfg_psel = 1'b0, cfg_penable = 1'b0, cfg_pwrite = 1'b0;
  logic [4:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  // Predictor state
  longint unsigned load_res, cal_ppm_r, cal_gain_r, out_gain_r, init_r0;
  logic [31:0] cal_r0;
  bit is_cal;
  reading_t pending_readings[$];
  int n_bad = 0;
  bit sink_stall_en = 1'b1;

  gas_sensor_ppm_linearizer dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Fixed-point helpers
  function automatic longint q_k();
    return (gsppm_pkg::LOG2_K_Q24 + 64'sd128) >>> 8;
  endfunction

  function automatic longint scale_q24(longint a, longint unsigned k);
    longint unsigned mag, r;
    mag = (a < 0) ? -a : a;
    r = (mag * k + (64'd1 << 23)) >> 24;
    return (a < 0) ? -longint'(r) : longint'(r);
  endfunction

  function automatic longint log2_q(longint unsigned x);
    int n;
    longint unsigned m, f;
    n = 63;
    f = 0;
    while (n > 0 && !x[n]) n--;
    m = (n >= 30) ? (x >> (n - 30)) : (x << (30 - n));
    for (int i = 0; i < FB; i++) begin
      m = (m * m) >> 30;
      f = f << 1;
      if (m >= (64'd2 << 30)) begin
        m = m >> 1;
        f = f | 1;
      end
    end
    return (longint'(n) <<< FB) + longint'(f);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint unsigned pow2_q(longint e);
    longint ip;
    longint unsigned f, m, root;
    int s;
    m = 64'd1 << 30;
    root = 64'd2 << 30;
    if (e >= 0) ip = e >>> FB;
    else ip = -longint'((longint'(-e) + (ONE - 1)) >> FB);
    f = e - ip * ONE;
    for (int i = 0; i < FB; i++) begin
      root = int_sqrt(root << 30);
      if (f[FB-1-i]) m = (m * root + (64'd1 << 29)) >> 30;
    end
    if (ip >= 34) return 64'd1 << 40;
    if (ip >= 30) return m << (ip - 30);
    s = 30 - ip;
    if (s > 62) return 0;
    return (m + (64'd1 << (s - 1))) >> s;
  endfunction

  function automatic reading_t predict_reading(logic kind, logic [11:0] adc);
    reading_t o;
    longint unsigned num, r0, nr;
    longint lrs, e;
    o = '0;
    num = 0;
    lrs = 0;
    if (adc == 0) begin
      o.st = gsppm_pkg::ST_ZERO;
    end else begin
      if (adc < FULL_SCALE) num = load_res * (FULL_SCALE - adc);
      if (num != 0) lrs = log2_q(num) - log2_q(adc);
      if (kind == gsppm_pkg::KIND_MEASURE) begin
        r0 = is_cal ? cal_r0 : init_r0;
        if (r0 == 0 || out_gain_r == 0) begin
          o.ppm = 0;
        end else if (num == 0) begin
          o.ppm = gsppm_pkg::PPM_MAX;
          o.st = gsppm_pkg::ST_SAT;
        end else begin
          e = q_k() + 4 * ONE - scale_q24(lrs - log2_q(r0), gsppm_pkg::EXPO_Q24)
              + log2_q(out_gain_r) - 8 * ONE;
          nr = pow2_q(e);
          if (nr > gsppm_pkg::PPM_MAX) begin
            o.ppm = gsppm_pkg::PPM_MAX;
            o.st = gsppm_pkg::ST_SAT;
          end else begin
            o.ppm = nr[23:0];
          end
        end
      end else begin
        if (num == 0 || cal_gain_r == 0 || cal_ppm_r == 0) begin
          nr = 0;
        end else begin
          e = lrs + log2_q(cal_gain_r) - 8 * ONE
              + scale_q24(log2_q(cal_ppm_r) - q_k(), gsppm_pkg::INV_EXPO_Q24);
          nr = pow2_q(e);
          if (nr > gsppm_pkg::R0_MAX) nr = gsppm_pkg::R0_MAX;
        end
        cal_r0 = nr[31:0];
        is_cal = 1'b1;
      end
    end
    o.r0 = is_cal ? cal_r0 : init_r0[31:0];
    return o;
  endfunction

  // Register write: setup then access, only while idle
  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    while (pending_readings.size() != 0) @(posedge clk);
    @(negedge clk);
    cfg_psel = 1'b1; cfg_pwrite = 1'b1;
    cfg_paddr = {idx, 2'b00}; cfg_pwdata = val;
    @(negedge clk);
    cfg_penable = 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    @(negedge clk);
    cfg_psel = 1'b0; cfg_penable = 1'b0; cfg_pwrite = 1'b0;
    case (idx)
      gsppm_pkg::REG_LOAD_RES: load_res = val[19:0];
      gsppm_pkg::REG_CAL_PPM:  cal_ppm_r = val[15:0];
      gsppm_pkg::REG_CAL_GAIN: cal_gain_r = val[15:0];
      gsppm_pkg::REG_OUT_GAIN: out_gain_r = val[15:0];
      gsppm_pkg::REG_INIT_R0:  init_r0 = val;
      default: ;
    endcase
  endtask

  task automatic idle_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return;
    repeat ((r < 92) ? $urandom_range(1, 3) : $urandom_range(10, 60)) @(negedge clk);
  endtask

  // Sends one transaction; prediction happens at acceptance
  task automatic send_sample(logic kind, logic [11:0] adc);
    idle_gap();
    @(negedge clk);
    in_tvalid = 1'b1;
    in_tuser = kind;
    in_tdata = {4'h0, adc};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_readings.push_back(predict_reading(kind, adc));
    @(negedge clk);
    in_tvalid = 1'b0;
  endtask

  task automatic drain();
    while (pending_readings.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  // Result sink: random stalls while sink_stall_en is set, checks against oldest prediction
  always @(negedge clk) begin
    int r;
    r = $urandom_range(0, 99);
    out_tready <= !sink_stall_en || (r < 70) || (r >= 97 ? 1'b0 : r < 85);
  end

  always @(posedge clk) begin
    reading_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_readings.size() == 0) begin
        n_bad++;
        if (n_bad <= 10) $display("unexpected result %h/%h", out_tdata, out_tuser);
      end else begin
        exp_r = pending_readings.pop_front();
        if (out_tdata[23:0] !== exp_r.ppm || out_tdata[55:24] !== exp_r.r0 ||
            out_tuser !== exp_r.st) begin
          n_bad++;
          if (n_bad <= 10)
            $display("exp ppm=%0d r0=%0d st=%0d got ppm=%0d r0=%0d st=%0d",
                     exp_r.ppm, exp_r.r0, exp_r.st, out_tdata[23:0],
                     out_tdata[55:24], out_tuser);
        end
      end
    end
  end

  task automatic test_directed();
    send_sample(gsppm_pkg::KIND_MEASURE, 12'd0);
    send_sample(gsppm_pkg::KIND_CAL, 12'd0);
    send_sample(gsppm_pkg::KIND_MEASURE, 12'd1);
    send_sample(gsppm_pkg::KIND_MEASURE, 12'd4095);
    send_sample(gsppm_pkg::KIND_MEASURE, 12'd4094);
    send_sample(gsppm_pkg::KIND_MEASURE, 12'd2048);
    send_sample(gsppm_pkg::KIND_MEASURE, 12'hAAA);
    send_sample(gsppm_pkg::KIND_MEASURE, 12'h555);
    send_sample(gsppm_pkg::KIND_CAL, 12'd2000);
    send_sample(gsppm_pkg::KIND_MEASURE, 12'd2000);
    send_sample(gsppm_pkg::KIND_CAL, 12'd4095);
    send_sample(gsppm_pkg::KIND_MEASURE, 12'd1000);
    send_sample(gsppm_pkg::KIND_CAL, 12'd1);
    send_sample(gsppm_pkg::KIND_MEASURE, 12'd4000);
    drain();
  endtask

  task automatic test_corner_regs();
    write_reg(gsppm_pkg::REG_OUT_GAIN, 32'd0);
    send_sample(gsppm_pkg::KIND_MEASURE, 12'd1500);
    write_reg(gsppm_pkg::REG_OUT_GAIN, 32'hFFFF);
    write_reg(gsppm_pkg::REG_LOAD_RES, 32'hFFFFF);
    send_sample(gsppm_pkg::KIND_MEASURE, 12'd1);
    send_sample(gsppm_pkg::KIND_MEASURE, 12'd3000);
    write_reg(gsppm_pkg::REG_LOAD_RES, 32'd0);
    send_sample(gsppm_pkg::KIND_MEASURE, 12'd100);
    write_reg(gsppm_pkg::REG_LOAD_RES, 32'hFFFFF);
    write_reg(gsppm_pkg::REG_CAL_GAIN, 32'hFFFF);
    write_reg(gsppm_pkg::REG_CAL_PPM, 32'd1);
    send_sample(gsppm_pkg::KIND_CAL, 12'd1);
    send_sample(gsppm_pkg::KIND_MEASURE, 12'd1);
    write_reg(gsppm_pkg::REG_CAL_GAIN, 32'd0);
    send_sample(gsppm_pkg::KIND_CAL, 12'd500);
    send_sample(gsppm_pkg::KIND_MEASURE, 12'd500);
    write_reg(gsppm_pkg::REG_CAL_GAIN, 32'd320);
    write_reg(gsppm_pkg::REG_CAL_PPM, 32'hFFFF);
    send_sample(gsppm_pkg::KIND_CAL, 12'd3500);
    drain();
  endtask

  task automatic test_random(int n);
    for (int p = 0; p < 8; p++) begin
      write_reg(gsppm_pkg::REG_LOAD_RES, (p == 0) ? 32'd1 : $urandom_range(1, 20'hFFFFF));
      write_reg(gsppm_pkg::REG_CAL_PPM, (p == 1) ? 32'hFFFF : $urandom_range(1, 16'hFFFF));
      write_reg(gsppm_pkg::REG_CAL_GAIN, (p == 2) ? 32'hFFFF : $urandom_range(0, 16'hFFFF));
      write_reg(gsppm_pkg::REG_OUT_GAIN, (p == 3) ? 32'hFFFF : $urandom_range(0, 1024));
      write_reg(gsppm_pkg::REG_INIT_R0,
                (p == 4) ? 32'hFFFFFFFF : (p == 5) ? 32'd1 : $urandom());
      sink_stall_en = (p != 6);
      for (int i = 0; i < n / 8; i++)
        send_sample(($urandom_range(0, 9) == 0) ? gsppm_pkg::KIND_CAL
                                                : gsppm_pkg::KIND_MEASURE,
                    ($urandom_range(0, 19) == 0) ? 12'(($urandom_range(0, 1)) ? 0 : 4095)
                                                 : 12'($urandom()));
      drain();
    end
    sink_stall_en = 1'b1;
  endtask

  initial begin
    load_res = 10000; cal_ppm_r = 10; cal_gain_r = 320; out_gain_r = 256;
    init_r0 = 10000; cal_r0 = 0; is_cal = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed();
    test_corner_regs();
    test_random(1120);
    if (n_bad == 0) $display("gas_sensor_ppm_linearizer: match");
    else $display("gas_sensor_ppm_linearizer: mismatch");
    $finish;
  end

  // Watchdog
  initial begin
    #20ms;
    $display("gas_sensor_ppm_linearizer: mismatch");
    $finish;
  end
endmodule
